// ===== design/bbpc_pkg.sv =====
// Shared types and constants for the bang-bang pressure controller.
// No dependencies; imported by bbpc_step and bang_bang_pressure_controller.
package bbpc_pkg;

  // Sanity window for sampled pressure, tenths of psi
  localparam logic signed [15:0] PRESSURE_MIN = -16'sd100;
  localparam logic signed [15:0] PRESSURE_MAX = 16'sd15000;

  // Widths of the stream and configuration payloads
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    MODE_DIS  = 2'd0,
    MODE_SUS  = 2'd1,
    MODE_VENT = 2'd2,
    MODE_ABT  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_UPDATE = 3'd0,
    OP_ENABLE = 3'd1,
    OP_DISABLE = 3'd2,
    OP_VENT   = 3'd3,
    OP_CLOSE  = 3'd4,
    OP_FCLOSE = 3'd5,
    OP_ABORT  = 3'd6,
    OP_SAFE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SANITY   = 3'd1,
    EV_CONFLICT = 3'd2,
    EV_NO_VENT  = 3'd3,
    EV_CLOSE_REJ = 3'd4,
    EV_VENT_IN  = 3'd5,
    EV_VENT_OUT = 3'd6,
    EV_ABORT_CLR = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_DEADBAND   = 3'd1,
    CFG_WAIT_MS    = 3'd2,
    CFG_MAX_OPEN   = 3'd3,
    CFG_VENT_TRIG  = 3'd4,
    CFG_TRIP_EN    = 3'd5,
    CFG_VENT_PRES  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic [14:0]        deadband;
    logic [31:0]        wait_ms;
    logic [31:0]        open_cap_ms;
    logic signed [15:0] vent_trigger;
    logic               trip_enable;
    logic               vent_present;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic               press;
    logic               vent;
    logic               latch;
    logic signed [15:0] last_p;
    logic               last_bad;
    logic [31:0]        open_time;
    logic [31:0]        switch_time;
  } state_t;

  typedef struct packed {
    op_e                opcode;
    logic               armed;
    logic signed [15:0] pressure;
    logic               pressure_bad;
    logic [15:0]        elapsed_ms;
  } item_t;

  typedef struct packed {
    event_e event_res;
    logic   accepted;
    logic   abort_latched;
    logic   vent_open;
    logic   press_open;
    mode_e  mode;
  } result_t;

endpackage

// ===== design/bbpc_step.sv =====
// Next-state and result logic for one tick or command of the controller.
// Purely combinational; depends on bbpc_pkg for state, config and item types.
module bbpc_step (
  input  bbpc_pkg::cfg_t    cfg_i,
  input  bbpc_pkg::state_t  state_i,
  input  bbpc_pkg::item_t   item_i,
  output bbpc_pkg::state_t  state_o,
  output bbpc_pkg::result_t result_o
);
  import bbpc_pkg::*;

  // Drive the press valve; opening restarts the open timer
  function automatic state_t set_press(state_t s, logic open);
    state_t r;
    r = s;
    if (open != s.press) begin
      r.press = open;
      if (open) r.open_time = '0;
    end
    return r;
  endfunction

  // Drive the vent valve only when one is fitted
  function automatic state_t set_vent(state_t s, logic open, logic present);
    state_t r;
    r = s;
    if (present) r.vent = open;
    return r;
  endfunction

  // Change mode; a real change restarts the switch timer
  function automatic state_t go_mode(state_t s, mode_e m);
    state_t r;
    r = s;
    if (m != s.mode) begin
      r.mode        = m;
      r.switch_time = '0;
    end
    return r;
  endfunction

  // Add elapsed time, saturating at all ones
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {17'd0, b};
    return t[32] ? '1 : t[31:0];
  endfunction

  state_t             s;
  logic               acc;
  event_e             ev;
  logic               was_latched;
  logic signed [17:0] hi2;
  logic signed [17:0] lo2;
  logic signed [17:0] p2;
  logic signed [17:0] p2_new;
  logic               p_out_of_range;

  // Thresholds on doubled values keep the half deadband exact
  assign hi2 = {cfg_i.setpoint[15], cfg_i.setpoint, 1'b0} + {3'b000, cfg_i.deadband};
  assign lo2 = {cfg_i.setpoint[15], cfg_i.setpoint, 1'b0} - {3'b000, cfg_i.deadband};
  assign p2     = {state_i.last_p[15], state_i.last_p, 1'b0};
  assign p2_new = {item_i.pressure[15], item_i.pressure, 1'b0};
  assign p_out_of_range = (item_i.pressure < PRESSURE_MIN) ||
                          (item_i.pressure > PRESSURE_MAX);
  assign was_latched = state_i.latch;

  always_comb begin
    s = state_i;
    acc = 1'b1;
    ev  = EV_NONE;

    // Advance both timers before anything else
    s.open_time   = sat_add(state_i.open_time, item_i.elapsed_ms);
    s.switch_time = sat_add(state_i.switch_time, item_i.elapsed_ms);

    case (item_i.opcode)
      OP_UPDATE: begin
        if (!item_i.armed) begin
          // Disarmed: safe everything if anything is active
          if (s.mode != MODE_DIS || s.press || s.vent || s.latch) begin
            s = set_press(s, 1'b0);
            s = set_vent(s, 1'b0, cfg_i.vent_present);
            s.latch = 1'b0;
            s = go_mode(s, MODE_DIS);
            ev = was_latched ? EV_ABORT_CLR : EV_NONE;
          end
        end else begin
          s.last_p   = item_i.pressure;
          s.last_bad = item_i.pressure_bad;
          if (s.mode != MODE_DIS && (item_i.pressure_bad || p_out_of_range)) begin
            // Sanity abort
            s = set_press(s, 1'b0);
            s = set_vent(s, 1'b1, cfg_i.vent_present);
            s.latch = 1'b1;
            s = go_mode(s, MODE_ABT);
            ev = EV_SANITY;
          end else if (s.mode == MODE_SUS) begin
            // Sustain: auto vent, open cap, then hysteresis after the wait
            if (cfg_i.trip_enable && cfg_i.vent_present &&
                item_i.pressure > cfg_i.vent_trigger) begin
              s = set_press(s, 1'b0);
              s = set_vent(s, 1'b1, cfg_i.vent_present);
              s = go_mode(s, MODE_VENT);
              ev = EV_VENT_IN;
            end else if (s.press && cfg_i.open_cap_ms != '0 &&
                         s.open_time >= cfg_i.open_cap_ms) begin
              s = set_press(s, 1'b0);
              s.switch_time = '0;
            end else if (s.switch_time >= cfg_i.wait_ms) begin
              if (p2_new > hi2 && s.press) begin
                s = set_press(s, 1'b0);
                s.switch_time = '0;
              end else if (p2_new < lo2 && !s.press) begin
                s = set_press(s, 1'b1);
                s.switch_time = '0;
              end
            end
          end else if (s.mode == MODE_VENT) begin
            // Leave auto vent once back at or below the top of the band
            if (p2_new <= hi2) begin
              s = set_vent(s, 1'b0, cfg_i.vent_present);
              s = go_mode(s, MODE_DIS);
              ev = EV_VENT_OUT;
            end
          end
        end
      end
      OP_ENABLE: begin
        if (s.mode != MODE_DIS) begin
          acc = 1'b0;
          ev  = EV_CONFLICT;
        end else begin
          s = go_mode(s, MODE_SUS);
        end
      end
      OP_DISABLE: begin
        if (s.mode == MODE_ABT) begin
          acc = 1'b0;
          ev  = EV_CONFLICT;
        end else begin
          s = set_press(s, 1'b0);
          if (s.mode == MODE_SUS) s = go_mode(s, MODE_DIS);
        end
      end
      OP_VENT: begin
        if (!cfg_i.vent_present) begin
          acc = 1'b0;
          ev  = EV_NO_VENT;
        end else if (s.mode == MODE_ABT) begin
          acc = 1'b0;
          ev  = EV_CONFLICT;
        end else begin
          s = set_press(s, 1'b0);
          s = set_vent(s, 1'b1, cfg_i.vent_present);
          s = go_mode(s, MODE_VENT);
          ev = EV_VENT_IN;
        end
      end
      OP_CLOSE, OP_FCLOSE: begin
        if (s.mode != MODE_VENT) begin
          acc = 1'b0;
        end else if (item_i.opcode == OP_CLOSE && !s.last_bad && p2 > hi2) begin
          // Plain close refused while still above the band
          acc = 1'b0;
          ev  = EV_CLOSE_REJ;
        end else begin
          s = set_vent(s, 1'b0, cfg_i.vent_present);
          s = go_mode(s, MODE_DIS);
          ev = EV_VENT_OUT;
        end
      end
      OP_ABORT: begin
        s = set_press(s, 1'b0);
        s = set_vent(s, 1'b1, cfg_i.vent_present);
        s.latch = 1'b1;
        s = go_mode(s, MODE_ABT);
        if (!cfg_i.vent_present) begin
          acc = 1'b0;
          ev  = EV_NO_VENT;
        end
      end
      default: begin
        // Force safe
        s = set_press(s, 1'b0);
        s = set_vent(s, 1'b0, cfg_i.vent_present);
        s.latch = 1'b0;
        s = go_mode(s, MODE_DIS);
        ev = was_latched ? EV_ABORT_CLR : EV_NONE;
      end
    endcase
  end

  assign state_o = s;

  // Report the state left by this item
  always_comb begin
    result_o.mode          = s.mode;
    result_o.press_open    = s.press;
    result_o.vent_open     = s.vent;
    result_o.abort_latched = s.latch;
    result_o.accepted      = acc;
    result_o.event_res     = ev;
  end

endmodule

// ===== design/bang_bang_pressure_controller.sv =====
// Top level of the bang-bang pressure controller: stream ports, config
// registers, controller state and a two-deep result buffer. Uses bbpc_pkg, bbpc_step.

// One word in, one word out, at one word per clock while the master side
// takes results. A word is taken while tready is high; its result goes to the
// output register, or to the skid entry if the master side holds that register.
// The update is one pass through the step logic into the state and result
// registers. The slave side takes one more word after the master side stalls,
// then tready drops until a result is drained. Configuration writes are taken
// every cycle and must be issued only while no word is in flight.
module bang_bang_pressure_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: armed[0], pressure[16:1], pressure_bad[17], elapsed_ms[33:18], zero[39:34]
  input  logic [bbpc_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: opcode[2:0]
  input  logic [bbpc_pkg::InUserW-1:0]   s_axis_tuser,
  // Master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: mode[1:0], press_open[2], vent_open[3], abort_latched[4],
  //        accepted[5], event_res[8:6], zero[15:9]
  output logic [bbpc_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbpc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [bbpc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bbpc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item;
  result_t res;
  logic    in_acc;
  logic    out_pop;

  logic    m_valid_q, m_valid_d;
  result_t m_data_q, m_data_d;
  logic    sk_valid_q, sk_valid_d;
  result_t sk_data_q, sk_data_d;

  // Unpack the incoming word
  assign item.opcode       = op_e'(s_axis_tuser);
  assign item.armed        = s_axis_tdata[0];
  assign item.pressure     = s_axis_tdata[16:1];
  assign item.pressure_bad = s_axis_tdata[17];
  assign item.elapsed_ms   = s_axis_tdata[33:18];

  assign s_axis_tready = !sk_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = m_valid_q && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  bbpc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (res)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint         <= '0;
      cfg_q.deadband         <= '0;
      cfg_q.wait_ms          <= '0;
      cfg_q.open_cap_ms      <= '0;
      cfg_q.vent_trigger     <= 16'sh7FFF;
      cfg_q.trip_enable      <= 1'b0;
      cfg_q.vent_present     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SETPOINT:  cfg_q.setpoint         <= cfg_data_i[15:0];
        CFG_DEADBAND:  cfg_q.deadband         <= cfg_data_i[14:0];
        CFG_WAIT_MS:   cfg_q.wait_ms          <= cfg_data_i;
        CFG_MAX_OPEN:  cfg_q.open_cap_ms      <= cfg_data_i;
        CFG_VENT_TRIG: cfg_q.vent_trigger     <= cfg_data_i[15:0];
        CFG_TRIP_EN:   cfg_q.trip_enable      <= cfg_data_i[0];
        CFG_VENT_PRES: cfg_q.vent_present     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Advance controller state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result buffer: output register backed by one skid entry
  always_comb begin
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    sk_valid_d = sk_valid_q;
    sk_data_d  = sk_data_q;
    if (!m_valid_q || out_pop) begin
      if (sk_valid_q) begin
        m_valid_d  = 1'b1;
        m_data_d   = sk_data_q;
        sk_valid_d = in_acc;
        if (in_acc) sk_data_d = res;
      end else begin
        m_valid_d = in_acc;
        if (in_acc) m_data_d = res;
      end
    end else if (in_acc) begin
      sk_valid_d = 1'b1;
      sk_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else begin
      m_valid_q  <= m_valid_d;
      sk_valid_q <= sk_valid_d;
    end
  end

  // Hold payload without reset
  always_ff @(posedge clk_i) begin
    m_data_q  <= m_data_d;
    sk_data_q <= sk_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_data_q};

endmodule

// ===== bench/tb_bang_bang_pressure_controller.sv =====
// Self-checking bench for bang_bang_pressure_controller: directed commands, then
// random ticks and commands under several register settings and idle patterns.
// Depends on bbpc_pkg and the controller RTL only.
module tb_bang_bang_pressure_controller;
  import bbpc_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 205;

  // Tracks valve and mode state and queues the result word each item should yield
  class valve_state_tracker;
    // register copies
    int          set_pt;
    logic [14:0] band;
    logic [31:0] wait_lim;
    logic [31:0] open_cap;
    int          vent_trip;
    bit          trip_en;
    bit          has_vent;
    // controller state
    mode_e       mode;
    bit          press;
    bit          vent;
    bit          latch;
    int          last_p;
    bit          last_bad;
    logic [31:0] open_t;
    logic [31:0] switch_t;
    result_t     pending_results[$];
    int          errors;

    function new();
      set_pt = 0; band = '0; wait_lim = '0; open_cap = '0;
      vent_trip = 32767; trip_en = 0; has_vent = 0;
      mode = MODE_DIS; press = 0; vent = 0; latch = 0;
      last_p = 0; last_bad = 0; open_t = '0; switch_t = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_SETPOINT:  set_pt = $signed(d[15:0]);
        CFG_DEADBAND:  band = d[14:0];
        CFG_WAIT_MS:   wait_lim = d;
        CFG_MAX_OPEN:  open_cap = d;
        CFG_VENT_TRIG: vent_trip = $signed(d[15:0]);
        CFG_TRIP_EN:   trip_en = d[0];
        CFG_VENT_PRES: has_vent = d[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + b;
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Band edges on doubled pressure, so the half deadband stays exact
    function int upper2();
      return 2 * set_pt + int'(band);
    endfunction

    function int lower2();
      return 2 * set_pt - int'(band);
    endfunction

    function void drive_press(bit open);
      if (open != press) begin
        press = open;
        if (open) open_t = '0;
      end
    endfunction

    function void drive_vent(bit open);
      if (has_vent) vent = open;
    endfunction

    function void go(mode_e m);
      if (m != mode) begin
        mode = m;
        switch_t = '0;
      end
    endfunction

    function event_e safe_all();
      bit was;
      was = latch;
      drive_press(0);
      drive_vent(0);
      latch = 0;
      go(MODE_DIS);
      return was ? EV_ABORT_CLR : EV_NONE;
    endfunction

    function bit abort_all();
      drive_press(0);
      drive_vent(1);
      latch = 1;
      go(MODE_ABT);
      return has_vent;
    endfunction

    // Auto vent, open cap and hysteresis control while sustaining
    function event_e regulate();
      if (trip_en && has_vent && last_p > vent_trip) begin
        drive_press(0);
        drive_vent(1);
        go(MODE_VENT);
        return EV_VENT_IN;
      end
      if (press && open_cap != 0 && open_t >= open_cap) begin
        drive_press(0);
        switch_t = '0;
        return EV_NONE;
      end
      if (switch_t < wait_lim) return EV_NONE;
      if (2 * last_p > upper2() && press) begin
        drive_press(0);
        switch_t = '0;
      end else if (2 * last_p < lower2() && !press) begin
        drive_press(1);
        switch_t = '0;
      end
      return EV_NONE;
    endfunction

    // Advance the state by one accepted word and queue its result
    function void take_command(item_t it);
      result_t r;
      bit      ok;
      event_e  ev;
      int      p;
      ok = 1;
      ev = EV_NONE;
      p = $signed(it.pressure);
      open_t = sat_add(open_t, it.elapsed_ms);
      switch_t = sat_add(switch_t, it.elapsed_ms);
      case (it.opcode)
        OP_UPDATE: begin
          if (!it.armed) begin
            if (mode != MODE_DIS || press || vent || latch) ev = safe_all();
          end else begin
            last_p = p;
            last_bad = it.pressure_bad;
            if (mode != MODE_DIS && (it.pressure_bad || p < int'(PRESSURE_MIN) ||
                                     p > int'(PRESSURE_MAX))) begin
              void'(abort_all());
              ev = EV_SANITY;
            end else if (mode == MODE_SUS) begin
              ev = regulate();
            end else if (mode == MODE_VENT && 2 * last_p <= upper2()) begin
              drive_vent(0);
              go(MODE_DIS);
              ev = EV_VENT_OUT;
            end
          end
        end
        OP_ENABLE: begin
          if (mode != MODE_DIS) begin
            ok = 0;
            ev = EV_CONFLICT;
          end else begin
            go(MODE_SUS);
          end
        end
        OP_DISABLE: begin
          if (mode == MODE_ABT) begin
            ok = 0;
            ev = EV_CONFLICT;
          end else begin
            drive_press(0);
            if (mode == MODE_SUS) go(MODE_DIS);
          end
        end
        OP_VENT: begin
          if (!has_vent) begin
            ok = 0;
            ev = EV_NO_VENT;
          end else if (mode == MODE_ABT) begin
            ok = 0;
            ev = EV_CONFLICT;
          end else begin
            drive_press(0);
            drive_vent(1);
            go(MODE_VENT);
            ev = EV_VENT_IN;
          end
        end
        OP_CLOSE, OP_FCLOSE: begin
          if (mode != MODE_VENT) begin
            ok = 0;
          end else if (it.opcode == OP_CLOSE && !last_bad && 2 * last_p > upper2()) begin
            ok = 0;
            ev = EV_CLOSE_REJ;
          end else begin
            drive_vent(0);
            go(MODE_DIS);
            ev = EV_VENT_OUT;
          end
        end
        OP_ABORT: begin
          if (!abort_all()) begin
            ok = 0;
            ev = EV_NO_VENT;
          end
        end
        default: ev = safe_all();
      endcase
      r.mode = mode;
      r.press_open = press;
      r.vent_open = vent;
      r.abort_latched = latch;
      r.accepted = ok;
      r.event_res = ev;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result word against the oldest expectation
    function void check_result(logic [OutDataW-1:0] w);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word %h arrived with nothing expected", w);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("mode", want.mode, w[1:0]);
      compare_field("press_open", want.press_open, w[2]);
      compare_field("vent_open", want.vent_open, w[3]);
      compare_field("abort_latched", want.abort_latched, w[4]);
      compare_field("accepted", want.accepted, w[5]);
      compare_field("event_res", want.event_res, w[8:6]);
    endfunction

    function void flag_leftovers();
      while (pending_results.size() > 0) begin
        void'(pending_results.pop_front());
        $error("expected result word never arrived");
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [InUserW-1:0]   s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgAddrW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  valve_state_tracker tracker = new();
  int send_idle_pct;
  int ready_stall_pct;
  int idle_cycles;

  bang_bang_pressure_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
  end

  // Watch all three channels at the rising edge
  always @(posedge clk_i) begin
    item_t seen;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.write_reg(cfg_idx_e'(cfg_addr_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        seen.opcode       = op_e'(s_axis_tuser);
        seen.armed        = s_axis_tdata[0];
        seen.pressure     = s_axis_tdata[16:1];
        seen.pressure_bad = s_axis_tdata[17];
        seen.elapsed_ms   = s_axis_tdata[33:18];
        tracker.take_command(seen);
      end
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bang_bang_pressure_controller: done, errors");
      $finish;
    end
  end

  function automatic item_t mk(op_e op, bit armed, logic signed [15:0] p, bit bad,
                               logic [15:0] el);
    item_t it;
    it.opcode = op;
    it.armed = armed;
    it.pressure = p;
    it.pressure_bad = bad;
    it.elapsed_ms = el;
    return it;
  endfunction

  function automatic logic signed [15:0] clamp_p(int v);
    if (v < int'(PRESSURE_MIN)) return PRESSURE_MIN;
    if (v > int'(PRESSURE_MAX)) return PRESSURE_MAX;
    return v[15:0];
  endfunction

  // Mostly armed ticks near the band or the trigger, with commands and noise mixed in
  function automatic item_t next_item();
    item_t it;
    int    sel;
    int    span;
    sel = $urandom_range(99);
    it.armed = 1'($urandom_range(1));
    it.pressure = 16'($urandom_range(65535));
    it.pressure_bad = 1'($urandom_range(1));
    if (tracker.mode == MODE_DIS && sel < 30) begin
      it.opcode = OP_ENABLE;
    end else if (sel < 82) begin
      it.opcode = OP_UPDATE;
      it.armed = ($urandom_range(99) >= 4);
      it.pressure_bad = ($urandom_range(99) < 3);
      sel = $urandom_range(99);
      span = int'(tracker.band) + 100;
      if (sel < 6)
        it.pressure = 16'($urandom_range(65535));
      else if (sel < 12)
        it.pressure = 16'(($urandom_range(1) ? int'(PRESSURE_MIN) : int'(PRESSURE_MAX))
                          + int'($urandom_range(10)) - 5);
      else if (sel < 22)
        it.pressure = clamp_p(tracker.vent_trip + int'($urandom_range(20)) - 10);
      else
        it.pressure = clamp_p(tracker.set_pt + int'($urandom_range(2 * span)) - span);
    end else begin
      it.opcode = op_e'($urandom_range(1, 7));
    end
    sel = $urandom_range(99);
    if (sel < 4)
      it.elapsed_ms = 16'hFFFF;
    else if (sel < 8)
      it.elapsed_ms = '0;
    else if (sel < 16)
      it.elapsed_ms = 16'($urandom_range(65535));
    else
      it.elapsed_ms = 16'($urandom_range(120));
    return it;
  endfunction

  // Present one word, idling first at random, and hold it until taken
  task automatic drive_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.elapsed_ms, it.pressure_bad, it.pressure, it.armed};
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every expected word to drain
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() > 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [15:0] sp, logic [14:0] db, logic [31:0] wt,
                            logic [31:0] cap, logic [15:0] trig, bit av, bit vp);
    write_reg(CFG_SETPOINT, {16'b0, sp});
    write_reg(CFG_DEADBAND, {17'b0, db});
    write_reg(CFG_WAIT_MS, wt);
    write_reg(CFG_MAX_OPEN, cap);
    write_reg(CFG_VENT_TRIG, {16'b0, trig});
    write_reg(CFG_TRIP_EN, {31'b0, av});
    write_reg(CFG_VENT_PRES, {31'b0, vp});
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int send_tab [4];
    int ready_tab [4];
    int sp;
    int trig;
    send_tab  = '{0, 51, 0, 6};
    ready_tab = '{0, 0, 51, 6};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    idle_cycles = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no vent valve, zero band
    drive_item(mk(OP_UPDATE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_CLOSE, 1, 16'sh7FFF, 1, 16'hFFFF));
    drive_item(mk(OP_ENABLE, 1, 16'sh7FFF, 1, 16'hFFFF));
    drive_item(mk(OP_ENABLE, 0, -16'sd1, 0, 16'd1));
    drive_item(mk(OP_UPDATE, 1, -16'sd32768, 0, 16'hFFFF));
    drive_item(mk(OP_ABORT, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_VENT, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_ENABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_DISABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_SAFE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_SAFE, 0, 16'sd0, 0, 16'd0));
    quiesce();

    // Vent valve present, band 990..1010, trigger 1200
    set_config(16'd1000, 15'd20, 32'd0, 32'd0, 16'd1200, 1'b1, 1'b1);
    drive_item(mk(OP_ENABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_UPDATE, 1, 16'sd900, 0, 16'd10));
    drive_item(mk(OP_UPDATE, 1, 16'sd1011, 0, 16'd10));
    drive_item(mk(OP_UPDATE, 1, 16'sd1201, 0, 16'd10));
    drive_item(mk(OP_CLOSE, 0, 16'sd0, 0, 16'd5));
    drive_item(mk(OP_FCLOSE, 0, 16'sd0, 0, 16'd5));
    drive_item(mk(OP_UPDATE, 1, 16'sh7FFF, 1, 16'd0));
    drive_item(mk(OP_VENT, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_CLOSE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_ENABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_UPDATE, 1, 16'sd15001, 0, 16'd0));
    drive_item(mk(OP_UPDATE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_ENABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_ABORT, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_SAFE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_ENABLE, 0, 16'sd0, 0, 16'd0));
    drive_item(mk(OP_DISABLE, 0, 16'sd0, 0, 16'd0));
    quiesce();

    // Random phases, each with its own settings and idle pattern
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) begin
        set_config(16'h8000, 15'd0, 32'd0, 32'd0, 16'h8000, 1'b0, 1'b0);
      end else if (ph == 1) begin
        set_config(16'h7FFF, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF,
                   1'b1, 1'b1);
      end else begin
        sp = $urandom_range(12000);
        trig = sp + int'($urandom_range(50, 2000));
        set_config(sp[15:0], 15'($urandom_range(400)), $urandom_range(300),
                   $urandom_range(1) ? 32'($urandom_range(1, 600)) : 32'd0,
                   trig[15:0], $urandom_range(99) < 80, $urandom_range(99) < 85);
      end
      send_idle_pct = send_tab[ph % 4];
      ready_stall_pct = ready_tab[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) drive_item(next_item());
      quiesce();
    end

    // Let late words arrive, then flag any expected word that never came
    repeat (4) @(posedge clk_i);
    tracker.flag_leftovers();
    if (tracker.errors == 0)
      $display("tb_bang_bang_pressure_controller: done, clean");
    else
      $display("tb_bang_bang_pressure_controller: done, errors");
    $finish;
  end

endmodule
